>>> rtl/hrd_pkg.sv
// heartbeat rate detector: shared constants, state codes and beat types
// no dependencies; used by every module of the block but hrd_ram
`default_nettype none

package hrd_pkg;

   localparam int WINDOW_DEPTH   = 128;
   localparam int INTERVAL_COUNT = 4;
   localparam int SAMPLE_BITS    = 16;

   localparam int INPUT_BITS    = 16;
   localparam int INTERVAL_BITS = 16;
   localparam int SPM_BITS      = 16;
   localparam int FRAC_BITS     = 8;
   localparam int BPM_BITS      = 10;
   localparam int BPM_MAX       = 999;

   localparam int WIN_AW       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int FILL_BITS    = $clog2(WINDOW_DEPTH + 1);
   localparam int RING_AW      = (INTERVAL_COUNT > 1) ? $clog2(INTERVAL_COUNT) : 1;
   localparam int SUM_BITS     = INTERVAL_BITS + $clog2(INTERVAL_COUNT);
   localparam int NUM_BITS     = SPM_BITS + $clog2(INTERVAL_COUNT);
   localparam int DIV_CNT_BITS = $clog2(NUM_BITS + 1);
   localparam int PROD_BITS    = SAMPLE_BITS + FRAC_BITS;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SAMPLES_PER_MINUTE = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UPPER_FRACTION     = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOWER_FRACTION     = 2'd2;

   localparam logic [SPM_BITS-1:0]  SPM_RESET   = 16'd1920;
   localparam logic [FRAC_BITS-1:0] UPPER_RESET = 8'd154;
   localparam logic [FRAC_BITS-1:0] LOWER_RESET = 8'd102;

   localparam logic [1:0] FRONT_IDLE = 2'd0;
   localparam logic [1:0] FRONT_SCAN = 2'd1;
   localparam logic [1:0] FRONT_PUSH = 2'd2;

   localparam logic [2:0] BACK_IDLE   = 3'd0;
   localparam logic [2:0] BACK_MUL    = 3'd1;
   localparam logic [2:0] BACK_DECIDE = 3'd2;
   localparam logic [2:0] BACK_DIV    = 3'd3;
   localparam logic [2:0] BACK_OUT    = 3'd4;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample;
      logic [SAMPLE_BITS-1:0] hi;
      logic [SAMPLE_BITS-1:0] lo;
   } win_item_type;

   typedef struct packed {
      logic [SPM_BITS-1:0]  spm;
      logic [FRAC_BITS-1:0] upper;
      logic [FRAC_BITS-1:0] lower;
   } cfg_type;

   typedef struct packed {
      logic                     beat;
      logic                     on_peak;
      logic [INTERVAL_BITS-1:0] last_interval;
      logic [BPM_BITS-1:0]      bpm;
   } rsp_type;

endpackage

`default_nettype wire

>>> rtl/hrd_ram.sv
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module hrd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

>>> rtl/hrd_queue.sv
// short queue of window results between the front and the back
// depends on hrd_pkg
`default_nettype none

module hrd_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire hrd_pkg::win_item_type push_item,
   output logic                      full,
   input  wire logic                 pop,
   output hrd_pkg::win_item_type     pop_item,
   output logic                      empty
);

   hrd_pkg::win_item_type entry_ff [hrd_pkg::QUEUE_DEPTH];
   logic [hrd_pkg::QUEUE_AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [hrd_pkg::QUEUE_AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [hrd_pkg::QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full     = (count_ff == hrd_pkg::QUEUE_CNT_BITS'(hrd_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == hrd_pkg::QUEUE_AW'(hrd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == hrd_pkg::QUEUE_AW'(hrd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

>>> rtl/hrd_front.sv
// front end: takes samples, writes the window ring and scans it for max and min
// depends on hrd_pkg and hrd_ram
`default_nettype none

module hrd_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_push,
   input  wire logic [hrd_pkg::INPUT_BITS-1:0]  req_sample,
   output logic                                 req_full,
   output logic                                 q_push,
   output hrd_pkg::win_item_type                q_item,
   input  wire logic                            q_full
);

   localparam logic [hrd_pkg::WIN_AW-1:0] LAST_IDX = hrd_pkg::WIN_AW'(hrd_pkg::WINDOW_DEPTH - 1);

   logic [1:0]                         state_ff, state_in;
   logic [hrd_pkg::WIN_AW-1:0]         wr_idx_ff, wr_idx_in;
   logic [hrd_pkg::FILL_BITS-1:0]      fill_ff, fill_in;
   logic [hrd_pkg::WIN_AW-1:0]         issue_idx_ff, issue_idx_in;
   logic                               issuing_ff, issuing_in;
   logic                               rd_valid_ff;
   logic [hrd_pkg::WIN_AW-1:0]         rd_idx_ff;
   logic [hrd_pkg::SAMPLE_BITS-1:0]    sample_ff, sample_in;
   logic [hrd_pkg::SAMPLE_BITS-1:0]    hi_ff, hi_in, lo_ff, lo_in;
   logic [hrd_pkg::SAMPLE_BITS-1:0]    rd_data, entry_val;
   logic                               ram_we;

   hrd_ram #(
      .WIDTH (hrd_pkg::SAMPLE_BITS),
      .DEPTH (hrd_pkg::WINDOW_DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_idx_ff),
      .wr_data (req_sample[hrd_pkg::SAMPLE_BITS-1:0]),
      .rd_addr (issue_idx_ff),
      .rd_data (rd_data)
   );

   // entries past the fill count are read as zero, whatever the ram holds there
   assign entry_val = (hrd_pkg::FILL_BITS'(rd_idx_ff) < fill_ff) ? rd_data : '0;

   assign req_full      = (state_ff != hrd_pkg::FRONT_IDLE);
   assign q_item.sample = sample_ff;
   assign q_item.hi     = hi_ff;
   assign q_item.lo     = lo_ff;

   always_comb begin
      state_in     = state_ff;
      wr_idx_in    = wr_idx_ff;
      fill_in      = fill_ff;
      issue_idx_in = issue_idx_ff;
      issuing_in   = issuing_ff;
      sample_in    = sample_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      ram_we       = 1'b0;
      q_push       = 1'b0;

      if (rd_valid_ff) begin
         if (rd_idx_ff == '0) begin
            hi_in = entry_val;
            lo_in = entry_val;
         end else begin
            if (entry_val > hi_ff) begin
               hi_in = entry_val;
            end
            if (entry_val < lo_ff) begin
               lo_in = entry_val;
            end
         end
      end

      case (state_ff)
         hrd_pkg::FRONT_IDLE: begin
            if (req_push) begin
               ram_we       = 1'b1;
               sample_in    = req_sample[hrd_pkg::SAMPLE_BITS-1:0];
               wr_idx_in    = (wr_idx_ff == LAST_IDX) ? '0 : wr_idx_ff + 1'b1;
               if (fill_ff != hrd_pkg::FILL_BITS'(hrd_pkg::WINDOW_DEPTH)) begin
                  fill_in = fill_ff + 1'b1;
               end
               issue_idx_in = '0;
               issuing_in   = 1'b1;
               state_in     = hrd_pkg::FRONT_SCAN;
            end
         end
         hrd_pkg::FRONT_SCAN: begin
            if (issuing_ff) begin
               if (issue_idx_ff == LAST_IDX) begin
                  issuing_in = 1'b0;
               end else begin
                  issue_idx_in = issue_idx_ff + 1'b1;
               end
            end
            if (rd_valid_ff && rd_idx_ff == LAST_IDX) begin
               state_in = hrd_pkg::FRONT_PUSH;
            end
         end
         hrd_pkg::FRONT_PUSH: begin
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = hrd_pkg::FRONT_IDLE;
            end
         end
         default: begin
            state_in = hrd_pkg::FRONT_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= hrd_pkg::FRONT_IDLE;
         wr_idx_ff   <= '0;
         fill_ff     <= '0;
         issuing_ff  <= 1'b0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         wr_idx_ff   <= wr_idx_in;
         fill_ff     <= fill_in;
         issuing_ff  <= issuing_in;
         rd_valid_ff <= issuing_ff;
      end
   end

   always_ff @(posedge clock) begin
      issue_idx_ff <= issue_idx_in;
      rd_idx_ff    <= issue_idx_ff;
      sample_ff    <= sample_in;
      hi_ff        <= hi_in;
      lo_ff        <= lo_in;
   end

endmodule

`default_nettype wire

>>> rtl/hrd_back.sv
// back end: thresholds, hysteresis, interval ring, serial rate divide, result register
// depends on hrd_pkg
`default_nettype none

module hrd_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire hrd_pkg::cfg_type      cfg,
   input  wire hrd_pkg::win_item_type q_item,
   input  wire logic                  q_empty,
   output logic                       q_pop,
   output logic                       rsp_valid,
   output hrd_pkg::rsp_type           rsp,
   input  wire logic                  rsp_pop
);

   localparam int SB = hrd_pkg::SAMPLE_BITS;
   localparam int IB = hrd_pkg::INTERVAL_BITS;

   logic [2:0]                           state_ff, state_in;
   logic [SB-1:0]                        sample_ff, sample_in;
   logic [SB-1:0]                        lo_ff, lo_in;
   logic [SB-1:0]                        range_ff, range_in;
   logic [hrd_pkg::PROD_BITS-1:0]        up_prod_ff, up_prod_in;
   logic [hrd_pkg::PROD_BITS-1:0]        low_prod_ff, low_prod_in;
   logic                                 peak_ff, peak_in;
   logic                                 beat_ff, beat_in;
   logic [IB-1:0]                        count_ff, count_in;
   logic [IB-1:0]                        ring_ff [hrd_pkg::INTERVAL_COUNT];
   logic [hrd_pkg::RING_AW-1:0]          ring_idx_ff, ring_idx_in;
   logic [hrd_pkg::SUM_BITS-1:0]         sum_ff, sum_in;
   logic [IB-1:0]                        last_ff, last_in;
   logic [hrd_pkg::SUM_BITS-1:0]         rem_ff, rem_in;
   logic [hrd_pkg::NUM_BITS-1:0]         num_ff, num_in;
   logic [hrd_pkg::DIV_CNT_BITS-1:0]     div_cnt_ff, div_cnt_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   hrd_pkg::rsp_type                     rsp_ff, rsp_in;

   logic [SB-1:0]                        upper_thr, lower_thr;
   logic [IB-1:0]                        count_inc;
   logic                                 ring_we;
   logic [hrd_pkg::SUM_BITS:0]           trial, diff;
   logic                                 qbit;
   logic [hrd_pkg::BPM_BITS-1:0]         bpm;

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign q_pop     = (state_ff == hrd_pkg::BACK_IDLE) && !q_empty;

   assign upper_thr = lo_ff + up_prod_ff[hrd_pkg::PROD_BITS-1:hrd_pkg::FRAC_BITS];
   assign lower_thr = lo_ff + low_prod_ff[hrd_pkg::PROD_BITS-1:hrd_pkg::FRAC_BITS];
   assign count_inc = (count_ff == '1) ? count_ff : count_ff + 1'b1;

   assign trial = {rem_ff, num_ff[hrd_pkg::NUM_BITS-1]};
   assign diff  = trial - {1'b0, sum_ff};
   assign qbit  = (trial >= {1'b0, sum_ff});

   always_comb begin
      if (sum_ff == '0) begin
         bpm = '0;
      end else if (num_ff > hrd_pkg::NUM_BITS'(hrd_pkg::BPM_MAX)) begin
         bpm = hrd_pkg::BPM_BITS'(hrd_pkg::BPM_MAX);
      end else begin
         bpm = num_ff[hrd_pkg::BPM_BITS-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      sample_in    = sample_ff;
      lo_in        = lo_ff;
      range_in     = range_ff;
      up_prod_in   = up_prod_ff;
      low_prod_in  = low_prod_ff;
      peak_in      = peak_ff;
      beat_in      = beat_ff;
      count_in     = count_ff;
      ring_idx_in  = ring_idx_ff;
      sum_in       = sum_ff;
      last_in      = last_ff;
      rem_in       = rem_ff;
      num_in       = num_ff;
      div_cnt_in   = div_cnt_ff;
      ring_we      = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      rsp_in       = rsp_ff;

      case (state_ff)
         hrd_pkg::BACK_IDLE: begin
            if (!q_empty) begin
               sample_in = q_item.sample;
               lo_in     = q_item.lo;
               range_in  = q_item.hi - q_item.lo;
               state_in  = hrd_pkg::BACK_MUL;
            end
         end
         hrd_pkg::BACK_MUL: begin
            up_prod_in  = hrd_pkg::PROD_BITS'(range_ff) * hrd_pkg::PROD_BITS'(cfg.upper);
            low_prod_in = hrd_pkg::PROD_BITS'(range_ff) * hrd_pkg::PROD_BITS'(cfg.lower);
            state_in    = hrd_pkg::BACK_DECIDE;
         end
         hrd_pkg::BACK_DECIDE: begin
            beat_in  = 1'b0;
            count_in = count_inc;
            if (peak_ff && sample_ff < lower_thr) begin
               peak_in = 1'b0;
            end else if (!peak_ff && sample_ff > upper_thr) begin
               peak_in     = 1'b1;
               beat_in     = 1'b1;
               ring_we     = 1'b1;
               count_in    = '0;
               last_in     = count_inc;
               sum_in      = sum_ff - hrd_pkg::SUM_BITS'(ring_ff[ring_idx_ff])
                             + hrd_pkg::SUM_BITS'(count_inc);
               ring_idx_in = (ring_idx_ff == hrd_pkg::RING_AW'(hrd_pkg::INTERVAL_COUNT - 1)) ?
                             '0 : ring_idx_ff + 1'b1;
            end
            num_in     = hrd_pkg::NUM_BITS'(hrd_pkg::INTERVAL_COUNT)
                         * hrd_pkg::NUM_BITS'(cfg.spm);
            rem_in     = '0;
            div_cnt_in = hrd_pkg::DIV_CNT_BITS'(hrd_pkg::NUM_BITS);
            state_in   = hrd_pkg::BACK_DIV;
         end
         hrd_pkg::BACK_DIV: begin
            // restoring divide, one quotient bit a cycle shifted into num
            rem_in     = qbit ? diff[hrd_pkg::SUM_BITS-1:0] : trial[hrd_pkg::SUM_BITS-1:0];
            num_in     = {num_ff[hrd_pkg::NUM_BITS-2:0], qbit};
            div_cnt_in = div_cnt_ff - 1'b1;
            if (div_cnt_ff == hrd_pkg::DIV_CNT_BITS'(1)) begin
               state_in = hrd_pkg::BACK_OUT;
            end
         end
         hrd_pkg::BACK_OUT: begin
            if (!rsp_valid_ff || rsp_pop) begin
               rsp_valid_in         = 1'b1;
               rsp_in.beat          = beat_ff;
               rsp_in.on_peak       = peak_ff;
               rsp_in.last_interval = last_ff;
               rsp_in.bpm           = bpm;
               state_in             = hrd_pkg::BACK_IDLE;
            end
         end
         default: begin
            state_in = hrd_pkg::BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hrd_pkg::BACK_IDLE;
         peak_ff      <= 1'b0;
         count_ff     <= '0;
         ring_idx_ff  <= '0;
         sum_ff       <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < hrd_pkg::INTERVAL_COUNT; i++) begin
            ring_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         peak_ff      <= peak_in;
         count_ff     <= count_in;
         ring_idx_ff  <= ring_idx_in;
         sum_ff       <= sum_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ring_we) begin
            ring_ff[ring_idx_ff] <= count_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      lo_ff       <= lo_in;
      range_ff    <= range_in;
      up_prod_ff  <= up_prod_in;
      low_prod_ff <= low_prod_in;
      beat_ff     <= beat_in;
      rem_ff      <= rem_in;
      num_ff      <= num_in;
      div_cnt_ff  <= div_cnt_in;
      rsp_ff      <= rsp_in;
   end

endmodule

`default_nettype wire

>>> rtl/heartbeat_rate_detector_top.sv
// heartbeat rate detector top level: config registers, front, queue and back
// depends on hrd_pkg, hrd_front, hrd_queue and hrd_back
//
//   channel  direction  handshake               payload
//   req      in         req_push / req_full     req_sample
//   rsp      out        rsp_pop / rsp_empty     beat, on_peak, last_interval, bpm
//   csr      in         csr_write_enable        csr_index, csr_write_data
//
// the front takes no new sample until it has done one write, then a read of every
// window entry through the single ram read port, and has pushed its result to the queue
// the back works on one window result at a time through idle, mul, decide, div and out, mostly the bit-serial divide
// no clearing pass after reset: a fill count makes unwritten window entries read as zero
// a two-beat queue and the result register let either side stall on its own
`default_nettype none

module heartbeat_rate_detector_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_push,
   output logic                                     req_full,
   input  wire logic [hrd_pkg::INPUT_BITS-1:0]      req_sample,
   output logic                                     rsp_empty,
   input  wire logic                                rsp_pop,
   output logic                                     rsp_beat_detected,
   output logic                                     rsp_on_peak,
   output logic      [hrd_pkg::INTERVAL_BITS-1:0]   rsp_last_interval,
   output logic      [hrd_pkg::BPM_BITS-1:0]        rsp_beats_per_minute,
   input  wire logic                                csr_write_enable,
   input  wire logic [hrd_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [hrd_pkg::CSR_DATA_BITS-1:0]   csr_write_data
);

   hrd_pkg::cfg_type      cfg_ff, cfg_in;
   hrd_pkg::win_item_type front_item, back_item;
   hrd_pkg::rsp_type      rsp;
   logic                  q_push, q_full, q_pop, q_empty, rsp_valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            hrd_pkg::CSR_SAMPLES_PER_MINUTE: begin
               cfg_in.spm = csr_write_data[hrd_pkg::SPM_BITS-1:0];
            end
            hrd_pkg::CSR_UPPER_FRACTION: begin
               cfg_in.upper = csr_write_data[hrd_pkg::FRAC_BITS-1:0];
            end
            hrd_pkg::CSR_LOWER_FRACTION: begin
               cfg_in.lower = csr_write_data[hrd_pkg::FRAC_BITS-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.spm   <= hrd_pkg::SPM_RESET;
         cfg_ff.upper <= hrd_pkg::UPPER_RESET;
         cfg_ff.lower <= hrd_pkg::LOWER_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   hrd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_sample (req_sample),
      .req_full   (req_full),
      .q_push     (q_push),
      .q_item     (front_item),
      .q_full     (q_full)
   );

   hrd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (back_item),
      .empty     (q_empty)
   );

   hrd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_item    (back_item),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .rsp_pop   (rsp_pop)
   );

   assign rsp_empty            = !rsp_valid;
   assign rsp_beat_detected    = rsp.beat;
   assign rsp_on_peak          = rsp.on_peak;
   assign rsp_last_interval    = rsp.last_interval;
   assign rsp_beats_per_minute = rsp.bpm;

   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full))
      else $error("window result pushed into a full queue");

   a_beat_means_on_peak: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (!rsp_beat_detected || rsp_on_peak))
      else $error("beat reported while off peak");

   a_bpm_saturated: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_beats_per_minute <= hrd_pkg::BPM_BITS'(hrd_pkg::BPM_MAX)))
      else $error("rate above saturation limit");

   a_front_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full) |=> req_full)
      else $error("front ready again straight after a sample beat");

endmodule

`default_nettype wire

>>> tb/tb_heartbeat_rate_detector_top.sv
`timescale 1ns / 1ps
// testbench for heartbeat_rate_detector_top: directed and random sample streams,
// each result checked against an in-bench model of the window, hysteresis and rate
// depends on hrd_pkg and heartbeat_rate_detector_top
`default_nettype none

module tb_heartbeat_rate_detector_top;

   logic                               clock;
   logic                               reset;
   logic                               req_push;
   logic                               req_full;
   logic [hrd_pkg::INPUT_BITS-1:0]     req_sample;
   logic                               rsp_empty;
   logic                               rsp_pop;
   logic                               rsp_beat_detected;
   logic                               rsp_on_peak;
   logic [hrd_pkg::INTERVAL_BITS-1:0]  rsp_last_interval;
   logic [hrd_pkg::BPM_BITS-1:0]       rsp_beats_per_minute;
   logic                               csr_write_enable;
   logic [hrd_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [hrd_pkg::CSR_DATA_BITS-1:0]  csr_write_data;

   heartbeat_rate_detector_top dut (
      .clock                (clock),
      .reset                (reset),
      .req_push             (req_push),
      .req_full             (req_full),
      .req_sample           (req_sample),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_beat_detected    (rsp_beat_detected),
      .rsp_on_peak          (rsp_on_peak),
      .rsp_last_interval    (rsp_last_interval),
      .rsp_beats_per_minute (rsp_beats_per_minute),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data)
   );

   // detector model state
   logic [hrd_pkg::SAMPLE_BITS-1:0]   window_copy [hrd_pkg::WINDOW_DEPTH];
   int unsigned                       window_slot;
   logic                              level_on_peak;
   logic [hrd_pkg::INTERVAL_BITS-1:0] count_since_beat;
   logic [hrd_pkg::INTERVAL_BITS-1:0] beat_intervals [hrd_pkg::INTERVAL_COUNT];
   int unsigned                       interval_slot;
   logic [hrd_pkg::SPM_BITS-1:0]      rate_scale;
   logic [hrd_pkg::FRAC_BITS-1:0]     upper_frac;
   logic [hrd_pkg::FRAC_BITS-1:0]     lower_frac;

   hrd_pkg::rsp_type pending_beats [$];
   int      failures;
   int      send_idle_pct;
   int      recv_idle_pct;
   int      hold_cycles;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("Test completed with failures");
      $finish;
   end

   task automatic clear_detector_model();
      for (int i = 0; i < hrd_pkg::WINDOW_DEPTH; i++) window_copy[i] = '0;
      for (int i = 0; i < hrd_pkg::INTERVAL_COUNT; i++) beat_intervals[i] = '0;
      window_slot      = 0;
      level_on_peak    = 1'b0;
      count_since_beat = '0;
      interval_slot    = 0;
      rate_scale       = hrd_pkg::SPM_RESET;
      upper_frac       = hrd_pkg::UPPER_RESET;
      lower_frac       = hrd_pkg::LOWER_RESET;
   endtask

   function automatic hrd_pkg::rsp_type detect_beat(
      input logic [hrd_pkg::INPUT_BITS-1:0] value);
      hrd_pkg::rsp_type                r;
      logic [hrd_pkg::SAMPLE_BITS-1:0] s;
      logic [hrd_pkg::SAMPLE_BITS-1:0] hi;
      logic [hrd_pkg::SAMPLE_BITS-1:0] lo;
      logic [31:0]                     span;
      logic [31:0]                     upper_level;
      logic [31:0]                     lower_level;
      logic [31:0]                     interval_sum;
      logic [31:0]                     rate;
      s = value[hrd_pkg::SAMPLE_BITS-1:0];
      window_copy[window_slot] = s;
      window_slot = (window_slot + 1) % hrd_pkg::WINDOW_DEPTH;
      hi = window_copy[0];
      lo = window_copy[0];
      for (int i = 1; i < hrd_pkg::WINDOW_DEPTH; i++) begin
         if (window_copy[i] > hi) hi = window_copy[i];
         if (window_copy[i] < lo) lo = window_copy[i];
      end
      span        = 32'(hi) - 32'(lo);
      upper_level = 32'(lo) + ((span * 32'(upper_frac)) >> 8);
      lower_level = 32'(lo) + ((span * 32'(lower_frac)) >> 8);
      if (count_since_beat != '1) count_since_beat++;
      r.beat = 1'b0;
      if (level_on_peak && 32'(s) < lower_level) begin
         level_on_peak = 1'b0;
      end else if (!level_on_peak && 32'(s) > upper_level) begin
         level_on_peak = 1'b1;
         r.beat = 1'b1;
         beat_intervals[interval_slot] = count_since_beat;
         count_since_beat = '0;
         interval_slot = (interval_slot + 1) % hrd_pkg::INTERVAL_COUNT;
      end
      r.on_peak = level_on_peak;
      r.last_interval = beat_intervals[(interval_slot + hrd_pkg::INTERVAL_COUNT - 1)
                                       % hrd_pkg::INTERVAL_COUNT];
      interval_sum = 0;
      for (int i = 0; i < hrd_pkg::INTERVAL_COUNT; i++) begin
         interval_sum += 32'(beat_intervals[i]);
      end
      if (interval_sum == 0) begin
         rate = 0;
      end else begin
         rate = (32'(hrd_pkg::INTERVAL_COUNT) * 32'(rate_scale)) / interval_sum;
         if (rate > 32'(hrd_pkg::BPM_MAX)) rate = 32'(hrd_pkg::BPM_MAX);
      end
      r.bpm = rate[hrd_pkg::BPM_BITS-1:0];
      return r;
   endfunction

   // result side: check every popped beat, random pops, long hold-offs on request
   initial begin
      hrd_pkg::rsp_type want;
      rsp_pop = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            if (pending_beats.size() == 0) begin
               $error("unexpected result: beat %0b on_peak %0b interval %0d bpm %0d",
                      rsp_beat_detected, rsp_on_peak, rsp_last_interval,
                      rsp_beats_per_minute);
               failures++;
            end else begin
               want = pending_beats.pop_front();
               if (rsp_beat_detected !== want.beat) begin
                  $error("beat_detected: expected %0b, got %0b", want.beat, rsp_beat_detected);
                  failures++;
               end
               if (rsp_on_peak !== want.on_peak) begin
                  $error("on_peak: expected %0b, got %0b", want.on_peak, rsp_on_peak);
                  failures++;
               end
               if (rsp_last_interval !== want.last_interval) begin
                  $error("last_interval: expected %0d, got %0d",
                         want.last_interval, rsp_last_interval);
                  failures++;
               end
               if (rsp_beats_per_minute !== want.bpm) begin
                  $error("beats_per_minute: expected %0d, got %0d",
                         want.bpm, rsp_beats_per_minute);
                  failures++;
               end
            end
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= (reset == 1'b0) && ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // push stays high after a beat so back-to-back samples need no extra edge
   task automatic send_sample(input logic [hrd_pkg::INPUT_BITS-1:0] value);
      if ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         if ($urandom_range(19) == 0) begin
            repeat ($urandom_range(160, 1)) @(posedge clock);
         end else begin
            do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
         end
      end
      req_push   <= 1'b1;
      req_sample <= value;
      do @(posedge clock); while (req_full);
      pending_beats.push_back(detect_beat(value));
   endtask

   task automatic wait_results_drained();
      req_push <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [hrd_pkg::CSR_INDEX_BITS-1:0] index,
                                 input logic [hrd_pkg::CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (index)
         hrd_pkg::CSR_SAMPLES_PER_MINUTE: rate_scale = data[hrd_pkg::SPM_BITS-1:0];
         hrd_pkg::CSR_UPPER_FRACTION:     upper_frac = data[hrd_pkg::FRAC_BITS-1:0];
         hrd_pkg::CSR_LOWER_FRACTION:     lower_frac = data[hrd_pkg::FRAC_BITS-1:0];
         default: ;
      endcase
   endtask

   function automatic logic [hrd_pkg::CSR_DATA_BITS-1:0] pick_fraction();
      int pick;
      pick = $urandom_range(5);
      if (pick == 0) return '0;
      if (pick == 1) return hrd_pkg::CSR_DATA_BITS'(8'hFF);
      return hrd_pkg::CSR_DATA_BITS'($urandom_range(255, 0));
   endfunction

   task automatic pick_random_settings();
      logic [hrd_pkg::CSR_DATA_BITS-1:0] spm;
      case ($urandom_range(9))
         0: spm = '0;
         1: spm = hrd_pkg::CSR_DATA_BITS'(1);
         2: spm = '1;
         3: spm = hrd_pkg::SPM_RESET;
         default: spm = hrd_pkg::CSR_DATA_BITS'($urandom_range(65535, 1));
      endcase
      wait_results_drained();
      write_register(hrd_pkg::CSR_SAMPLES_PER_MINUTE, spm);
      write_register(hrd_pkg::CSR_UPPER_FRACTION, pick_fraction());
      write_register(hrd_pkg::CSR_LOWER_FRACTION, pick_fraction());
   endtask

   // a run of pulses with random period, duty, level and jitter, cut off at budget
   task automatic send_pulse_train(input int budget, output int sent);
      int period;
      int width;
      int beats;
      int base;
      int amp;
      int jitter;
      if ($urandom_range(24) == 0) begin
         period = $urandom_range(160, 60);
         beats  = 2;
      end else begin
         period = $urandom_range(30, 2);
         beats  = $urandom_range(6, 2);
      end
      width  = $urandom_range(period - 1, 1);
      base   = $urandom_range(30000, 0);
      amp    = $urandom_range(65535 - base, 2000);
      jitter = amp / 8 + 1;
      sent   = 0;
      for (int b = 0; b < beats; b++) begin
         for (int k = 0; k < period; k++) begin
            if (sent >= budget) return;
            if (k < width) begin
               send_sample(hrd_pkg::INPUT_BITS'(base + amp
                                                - int'($urandom_range(jitter - 1, 0))));
            end else begin
               send_sample(hrd_pkg::INPUT_BITS'(base + int'($urandom_range(jitter - 1, 0))));
            end
            sent++;
         end
      end
   endtask

   task automatic test_flat_window_start();
      send_sample('0);
      send_sample('0);
      send_sample(hrd_pkg::INPUT_BITS'(1));
      send_sample('0);
      send_sample('1);
      send_sample('0);
      send_sample('1);
      send_sample('0);
      wait_results_drained();
   endtask

   task automatic test_threshold_extremes();
      // crossed fractions
      write_register(hrd_pkg::CSR_UPPER_FRACTION, '0);
      write_register(hrd_pkg::CSR_LOWER_FRACTION, hrd_pkg::CSR_DATA_BITS'(8'hFF));
      send_sample('1);
      send_sample(hrd_pkg::INPUT_BITS'(100));
      send_sample('0);
      send_sample('1);
      send_sample(hrd_pkg::INPUT_BITS'(40000));
      send_sample('0);
      wait_results_drained();
      write_register(hrd_pkg::CSR_UPPER_FRACTION, hrd_pkg::CSR_DATA_BITS'(8'hFF));
      write_register(hrd_pkg::CSR_LOWER_FRACTION, '0);
      send_sample('1);
      send_sample('0);
      send_sample(hrd_pkg::INPUT_BITS'(16'hFFFE));
      send_sample(hrd_pkg::INPUT_BITS'(1));
      wait_results_drained();
   endtask

   task automatic test_rate_extremes();
      write_register(hrd_pkg::CSR_UPPER_FRACTION,
                     hrd_pkg::CSR_DATA_BITS'(hrd_pkg::UPPER_RESET));
      write_register(hrd_pkg::CSR_LOWER_FRACTION,
                     hrd_pkg::CSR_DATA_BITS'(hrd_pkg::LOWER_RESET));
      write_register(hrd_pkg::CSR_SAMPLES_PER_MINUTE, '0);
      send_sample('1);
      send_sample('0);
      send_sample('1);
      send_sample('0);
      wait_results_drained();
      write_register(hrd_pkg::CSR_SAMPLES_PER_MINUTE, '1);
      send_sample('1);
      send_sample('0);
      send_sample('1);
      wait_results_drained();
      write_register(hrd_pkg::CSR_SAMPLES_PER_MINUTE, hrd_pkg::CSR_DATA_BITS'(1));
      send_sample('0);
      send_sample('1);
      wait_results_drained();
   endtask

   task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                      input int item_count);
      int sent;
      int burst;
      int kind;
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      pick_random_settings();
      sent = 0;
      while (sent < item_count) begin
         kind = $urandom_range(99);
         if (kind < 75) begin
            send_pulse_train(item_count - sent, burst);
            sent += burst;
         end else if (kind < 92) begin
            burst = $urandom_range(12, 3);
            for (int i = 0; i < burst; i++) begin
               send_sample(hrd_pkg::INPUT_BITS'($urandom_range(65535, 0)));
            end
            sent += burst;
         end else begin
            pick_random_settings();
         end
      end
      wait_results_drained();
   endtask

   task automatic test_full_backpressure();
      send_idle_pct = 0;
      hold_cycles   = 2000;
      for (int i = 0; i < 10; i++) begin
         send_sample(i[0] ? hrd_pkg::INPUT_BITS'($urandom_range(65535, 50000))
                          : hrd_pkg::INPUT_BITS'($urandom_range(10000, 0)));
      end
      wait_results_drained();
   endtask

   initial begin
      req_push         = 1'b0;
      req_sample       = '0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      reset            = 1'b1;
      failures         = 0;
      hold_cycles      = 0;
      send_idle_pct    = 31;
      recv_idle_pct    = 56;
      clear_detector_model();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_flat_window_start();
      test_threshold_extremes();
      test_rate_extremes();
      test_random_traffic(31, 56, 165);
      test_full_backpressure();
      test_random_traffic(56, 31, 165);
      test_random_traffic(0, 0, 165);

      wait_results_drained();
      repeat (300) @(posedge clock);
      if (failures == 0 && pending_beats.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> heartbeat_rate_detector_top.f
rtl/hrd_pkg.sv
rtl/hrd_ram.sv
rtl/hrd_queue.sv
rtl/hrd_front.sv
rtl/hrd_back.sv
rtl/heartbeat_rate_detector_top.sv
tb/tb_heartbeat_rate_detector_top.sv
